// File: hdl/cgss_pkg.sv
package cgss_pkg;

  localparam int unsigned ACC_COUNT_DEF = 256;
  localparam logic [15:0] SCALE_RESET   = 16'h3C00;
  localparam logic [15:0] HALF_QNAN     = 16'h7E00;
  localparam logic [15:0] HALF_INF      = 16'h7C00;
  localparam logic [15:0] SIGN_BIT      = 16'h8000;
  localparam int          WIDE_SHIFT    = 38;

  typedef logic signed [11:0] exp_t;

  typedef struct packed {
    logic        neg;
    logic [63:0] mag;
    exp_t        ex;
  } term_t;

  // Load strobes from the sequencer to the arithmetic unit.
  typedef struct packed {
    logic ld_d;
    logic ld_p;
    logic ld_f;
    logic clr_sum;
    logic ld_sum;
  } dp_ctl_t;

  function automatic logic h_nan(logic [15:0] h);
    return (h[14:10] == 5'h1F) && (h[9:0] != 10'd0);
  endfunction

  function automatic logic h_inf(logic [15:0] h);
    return h[14:0] == HALF_INF[14:0];
  endfunction

  function automatic logic h_zero(logic [15:0] h);
    return h[14:0] == 15'd0;
  endfunction

  function automatic term_t unpack(logic [15:0] h);
    term_t t;
    t.neg = h[15];
    if (h[14:10] == 5'd0) begin
      t.mag = {54'd0, h[9:0]};
      t.ex  = -12'sd24;
    end else begin
      t.mag = {53'd0, 1'b1, h[9:0]};
      t.ex  = exp_t'({7'd0, h[14:10]}) - 12'sd25;
    end
    return t;
  endfunction

  // Rounds neg * m * 2^e to fp16, nearest even.
  function automatic logic [15:0] round_pack(logic neg, logic [63:0] m, exp_t e);
    logic [15:0] sign;
    logic [5:0]  msb;
    exp_t        ex;
    exp_t        q;
    exp_t        s;
    exp_t        ns;
    logic [63:0] kept;
    logic [63:0] rem;
    logic [63:0] half;
    logic [4:0]  ebits;
    logic [16:0] bits;
    sign = neg ? SIGN_BIT : 16'h0000;
    msb  = 6'd0;
    for (int i = 0; i < 64; i++) begin
      if (m[i]) msb = 6'(i);
    end
    ex = exp_t'({6'd0, msb}) + e;
    if (m == 64'd0) return sign;
    if (ex > 12'sd15) return sign | HALF_INF;
    q  = ((ex < -12'sd14) ? -12'sd14 : ex) - 12'sd10;
    s  = q - e;
    ns = -s;
    if (s <= 12'sd0) begin
      kept = m << ns[6:0];
    end else if (s >= 12'sd64) begin
      kept = 64'd0;
    end else begin
      rem  = m & ((64'd1 << s[5:0]) - 64'd1);
      half = 64'd1 << (s[5:0] - 6'd1);
      kept = m >> s[5:0];
      if ((rem > half) || ((rem == half) && kept[0])) kept = kept + 64'd1;
    end
    ebits = 5'(ex + 12'sd14);
    if (ex < -12'sd14) bits = kept[16:0];
    else bits = {2'b00, ebits, 10'd0} + kept[16:0];
    if (bits >= {1'b0, HALF_INF}) bits = {1'b0, HALF_INF};
    return sign | bits[15:0];
  endfunction

  // Exact sum of two finite terms with a single rounding.
  function automatic logic [15:0] add_terms(term_t a_in, term_t b_in);
    term_t       a;
    term_t       b;
    exp_t        diff;
    exp_t        k;
    exp_t        base;
    logic [63:0] big;
    logic [63:0] small_m;
    logic [63:0] mag;
    logic        neg;
    a = a_in;
    b = b_in;
    if ((a.mag == 64'd0) && (b.mag == 64'd0)) return (a.neg & b.neg) ? SIGN_BIT : 16'h0000;
    if (a.mag == 64'd0) return round_pack(b.neg, b.mag, b.ex);
    if (b.mag == 64'd0) return round_pack(a.neg, a.mag, a.ex);
    if (a.ex < b.ex) begin
      a = b_in;
      b = a_in;
    end
    diff = a.ex - b.ex;
    if (diff > exp_t'(WIDE_SHIFT)) begin
      k    = diff - exp_t'(WIDE_SHIFT);
      big  = a.mag << WIDE_SHIFT;
      base = a.ex - exp_t'(WIDE_SHIFT);
      if (k >= 12'sd63) begin
        small_m = 64'd1;
      end else begin
        small_m = b.mag >> k[5:0];
        if ((b.mag & ((64'd1 << k[5:0]) - 64'd1)) != 64'd0) small_m[0] = 1'b1;
      end
    end else begin
      big     = a.mag << diff[5:0];
      small_m = b.mag;
      base    = b.ex;
    end
    if (a.neg == b.neg) begin
      mag = big + small_m;
      neg = a.neg;
    end else if (big >= small_m) begin
      mag = big - small_m;
      neg = a.neg;
    end else begin
      mag = small_m - big;
      neg = b.neg;
    end
    if (mag == 64'd0) return 16'h0000;
    return round_pack(neg, mag, base);
  endfunction

  function automatic logic [15:0] half_add(logic [15:0] x, logic [15:0] y);
    if (h_nan(x) || h_nan(y)) return HALF_QNAN;
    if (h_inf(x)) begin
      if (h_inf(y) && (x[15] != y[15])) return HALF_QNAN;
      return x;
    end
    if (h_inf(y)) return y;
    return add_terms(unpack(x), unpack(y));
  endfunction

  function automatic logic [15:0] half_mul(logic [15:0] x, logic [15:0] y);
    logic  neg;
    term_t a;
    term_t b;
    logic [21:0] prod;
    neg = x[15] ^ y[15];
    if (h_nan(x) || h_nan(y)) return HALF_QNAN;
    if (h_inf(x) || h_inf(y)) begin
      if (h_zero(x) || h_zero(y)) return HALF_QNAN;
      return (neg ? SIGN_BIT : 16'h0000) | HALF_INF;
    end
    a    = unpack(x);
    b    = unpack(y);
    prod = a.mag[10:0] * b.mag[10:0];
    return round_pack(neg, {42'd0, prod}, a.ex + b.ex);
  endfunction

  function automatic logic [15:0] half_fma(logic [15:0] x, logic [15:0] y, logic [15:0] z);
    logic  pneg;
    term_t a;
    term_t b;
    term_t p;
    logic [21:0] prod;
    pneg = x[15] ^ y[15];
    if (h_nan(x) || h_nan(y) || h_nan(z)) return HALF_QNAN;
    if (h_inf(x) || h_inf(y)) begin
      if (h_zero(x) || h_zero(y)) return HALF_QNAN;
      if (h_inf(z) && (z[15] != pneg)) return HALF_QNAN;
      return (pneg ? SIGN_BIT : 16'h0000) | HALF_INF;
    end
    if (h_inf(z)) return z;
    a     = unpack(x);
    b     = unpack(y);
    prod  = a.mag[10:0] * b.mag[10:0];
    p.neg = pneg;
    p.mag = {42'd0, prod};
    p.ex  = a.ex + b.ex;
    return add_terms(p, unpack(z));
  endfunction

  typedef enum logic [8:0] {
    ST_CLR  = 9'b000000001,
    ST_IDLE = 9'b000000010,
    ST_D    = 9'b000000100,
    ST_P    = 9'b000001000,
    ST_F    = 9'b000010000,
    ST_W    = 9'b000100000,
    ST_RRD  = 9'b001000000,
    ST_RACC = 9'b010000000,
    ST_EMIT = 9'b100000000
  } state_t;

endpackage

// File: hdl/centered_group_square_sum_fp16.sv
// A sample without the group-end flag passes through states D, P, F and W before the next
// request is taken. A group-end sample then adds a reduction walk over every lane, alternating
// a lane read and a lane add through the single lane memory, then loads the result.
// An empty-group request goes straight to the emit state and presents its result once the
// output is free. Reset: synchronous, active low; a clearing pass then writes +0 to every lane
// while input requests are held off. Configuration writes are taken throughout.
module centered_group_square_sum_fp16 #(
  parameter int unsigned ACCUMULATOR_COUNT = cgss_pkg::ACC_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_sample,
  input  logic [15:0] in_group_mean,
  input  logic        in_last_in_group,
  input  logic        in_empty_group,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_group_sum,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import cgss_pkg::*;

  localparam int unsigned AW = (ACCUMULATOR_COUNT > 1) ? $clog2(ACCUMULATOR_COUNT) : 1;
  localparam logic [AW-1:0] LAST_LANE = AW'(ACCUMULATOR_COUNT - 1);

  // The scale register sits at byte address zero; bit 2 selects the register word.
  logic [15:0] scale_r;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == 1'b0) ? {16'd0, scale_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= SCALE_RESET;
    end else if (cfg_wr && (paddr[2] == 1'b0)) begin
      scale_r <= pwdata[15:0];
    end
  end

  // Sequencer state. The request payload is captured at acceptance so the
  // arithmetic can use it over the following cycles.
  state_t      state_r, state_nxt;
  logic [AW-1:0] pos_r, pos_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic [15:0] sample_r;
  logic [15:0] mean_r;
  logic        last_r;
  logic        out_valid_r, out_valid_nxt;
  logic [15:0] out_data_r;
  logic        in_acc;
  logic        load_ok;

  logic          mem_wr_en;
  logic [AW-1:0] mem_wr_addr;
  logic [15:0]   mem_wr_data;
  logic          mem_rd_en;
  logic [AW-1:0] mem_rd_addr;
  logic [15:0]   mem_rd_data;
  logic [15:0]   fma_val;
  logic [15:0]   sum_val;
  dp_ctl_t       ctl;

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  // The output register can take a new result when empty or being drained.
  assign load_ok  = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    mem_wr_en     = 1'b0;
    mem_wr_addr   = idx_r;
    mem_wr_data   = 16'h0000;
    mem_rd_en     = 1'b0;
    mem_rd_addr   = idx_r;
    ctl           = '0;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    unique case (state_r)
      ST_CLR: begin
        // Post-reset sweep that writes +0 to every lane.
        mem_wr_en = 1'b1;
        idx_nxt   = idx_r + AW'(1);
        if (idx_r == LAST_LANE) begin
          idx_nxt   = '0;
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          ctl.clr_sum = 1'b1;
          if (in_empty_group) begin
            state_nxt = ST_EMIT;
          end else begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = pos_r;
            state_nxt   = ST_D;
          end
        end
      end
      ST_D: begin
        ctl.ld_d  = 1'b1;
        state_nxt = ST_P;
      end
      ST_P: begin
        ctl.ld_p  = 1'b1;
        state_nxt = ST_F;
      end
      ST_F: begin
        ctl.ld_f  = 1'b1;
        state_nxt = ST_W;
      end
      ST_W: begin
        // Write back the updated lane; the next request cannot touch it
        // before this write lands, so no forwarding is needed.
        mem_wr_en   = 1'b1;
        mem_wr_addr = pos_r;
        mem_wr_data = fma_val;
        if (last_r) begin
          pos_nxt   = '0;
          idx_nxt   = '0;
          state_nxt = ST_RRD;
        end else begin
          pos_nxt   = (pos_r == LAST_LANE) ? '0 : pos_r + AW'(1);
          state_nxt = ST_IDLE;
        end
      end
      ST_RRD: begin
        mem_rd_en = 1'b1;
        state_nxt = ST_RACC;
      end
      ST_RACC: begin
        // Add the lane into the running sum and clear it in the same cycle.
        ctl.ld_sum = 1'b1;
        mem_wr_en  = 1'b1;
        if (idx_r == LAST_LANE) begin
          idx_nxt   = '0;
          state_nxt = ST_EMIT;
        end else begin
          idx_nxt   = idx_r + AW'(1);
          state_nxt = ST_RRD;
        end
      end
      ST_EMIT: begin
        if (load_ok) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      pos_r       <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      sample_r <= in_sample;
      mean_r   <= in_group_mean;
      last_r   <= in_last_in_group;
    end
    if ((state_r == ST_EMIT) && load_ok) begin
      out_data_r <= sum_val;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_group_sum = out_data_r;

  cgss_lane_mem #(
    .DEPTH (ACCUMULATOR_COUNT),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  cgss_datapath u_dp (
    .clk      (clk),
    .ctl      (ctl),
    .sample   (sample_r),
    .mean     (mean_r),
    .scale    (scale_r),
    .lane_val (mem_rd_data),
    .fma_val  (fma_val),
    .sum_val  (sum_val)
  );

  a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) && load_ok |=> out_valid_r)
    else $error("result not presented after emit");

  a_walk_from_lane0: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_W) && last_r |=> (idx_r == '0) && (pos_r == '0))
    else $error("reduction walk does not start at lane zero");

  a_no_result_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLR) |-> !out_valid_r && in_stall)
    else $error("activity during clearing pass");

  a_read_before_add: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RACC) |-> ($past(state_r) == ST_RRD))
    else $error("lane add without preceding read");

endmodule

// File: hdl/cgss_lane_mem.sv
module cgss_lane_mem #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = 8
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [15:0]   wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [15:0]   rd_data
);

  logic [15:0] mem [DEPTH];
  logic [15:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: hdl/cgss_datapath.sv
module cgss_datapath (
  input  logic             clk,
  input  cgss_pkg::dp_ctl_t ctl,
  input  logic [15:0]      sample,
  input  logic [15:0]      mean,
  input  logic [15:0]      scale,
  input  logic [15:0]      lane_val,
  output logic [15:0]      fma_val,
  output logic [15:0]      sum_val
);
  import cgss_pkg::*;

  logic [15:0] d_r;
  logic [15:0] p_r;
  logic [15:0] f_r;
  logic [15:0] sum_r;

  // One fp16 operation per cycle, each result registered.
  always_ff @(posedge clk) begin
    if (ctl.ld_d) d_r <= half_add(sample, mean ^ SIGN_BIT);
    if (ctl.ld_p) p_r <= half_mul(d_r, scale);
    if (ctl.ld_f) f_r <= half_fma(p_r, d_r, lane_val);
    if (ctl.clr_sum) begin
      sum_r <= 16'h0000;
    end else if (ctl.ld_sum) begin
      sum_r <= half_add(sum_r, lane_val);
    end
  end

  assign fma_val = f_r;
  assign sum_val = sum_r;

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 100ps

// Testbench for the centered group square sum block. A scoreboard class
// predicts the fp16 group sum for every accepted group-end or empty-group
// request and checks each returned sum, in order, against the oldest prediction.
typedef struct {
  bit              neg;
  longint unsigned mag;
  int              ex;
} half_term_t;

class sumsq_scoreboard;
  logic [15:0] lanes[cgss_pkg::ACC_COUNT_DEF];
  int unsigned lane_pos;
  logic [15:0] scale;
  logic [15:0] expected_sums[$];
  int unsigned errors;

  function new();
    foreach (lanes[i]) lanes[i] = 16'h0000;
    lane_pos = 0;
    scale = cgss_pkg::SCALE_RESET;
    errors = 0;
  endfunction

  function void report(string what, logic [15:0] got, logic [15:0] want);
    $display("%0t mismatch: %s got %h want %h", $time, what, got, want);
    errors++;
  endfunction

  function bit is_nan(logic [15:0] h);
    return (h[14:10] == 5'h1F) && (h[9:0] != 10'd0);
  endfunction

  function bit is_inf(logic [15:0] h);
    return h[14:0] == 15'h7C00;
  endfunction

  function half_term_t split(logic [15:0] h);
    half_term_t t;
    t.neg = h[15];
    if (h[14:10] == 5'd0) begin
      t.mag = h[9:0];
      t.ex = -24;
    end else begin
      t.mag = {1'b1, h[9:0]};
      t.ex = int'(h[14:10]) - 25;
    end
    return t;
  endfunction

  // Rounds (-1)^neg * m * 2^e to fp16, nearest even, keeping subnormals.
  function logic [15:0] pack_rne(bit neg, longint unsigned m, int e);
    logic [15:0] sgn;
    int top, ex, q, s;
    longint unsigned kept, rem, half;
    int unsigned bits;
    sgn = neg ? cgss_pkg::SIGN_BIT : 16'h0000;
    if (m == 0) return sgn;
    top = 63;
    while (m[top] == 1'b0) top--;
    ex = top + e;
    if (ex > 15) return sgn | cgss_pkg::HALF_INF;
    q = ((ex < -14) ? -14 : ex) - 10;
    s = q - e;
    if (s <= 0) begin
      kept = m << (-s);
    end else if (s >= 64) begin
      kept = 0;
    end else begin
      rem = m & ((64'd1 << s) - 64'd1);
      half = 64'd1 << (s - 1);
      kept = m >> s;
      if (rem > half || (rem == half && kept[0])) kept++;
    end
    if (ex < -14) bits = kept[31:0];
    else bits = ((ex + 14) << 10) + kept[31:0];
    if (bits >= 32'h7C00) bits = 32'h7C00;
    return sgn | bits[15:0];
  endfunction

  // Exact sum of two finite terms with one rounding at the end.
  function logic [15:0] sum_terms(half_term_t a, half_term_t b);
    half_term_t t;
    longint unsigned big, lil, mag;
    int base, diff, k;
    bit neg;
    if (a.mag == 0 && b.mag == 0) return (a.neg & b.neg) ? cgss_pkg::SIGN_BIT : 16'h0000;
    if (a.mag == 0) return pack_rne(b.neg, b.mag, b.ex);
    if (b.mag == 0) return pack_rne(a.neg, a.mag, a.ex);
    if (a.ex < b.ex) begin
      t = a;
      a = b;
      b = t;
    end
    diff = a.ex - b.ex;
    if (diff > cgss_pkg::WIDE_SHIFT) begin
      // Far smaller addend collapses into a sticky bit below the wide window.
      k = diff - cgss_pkg::WIDE_SHIFT;
      big = a.mag << cgss_pkg::WIDE_SHIFT;
      base = a.ex - cgss_pkg::WIDE_SHIFT;
      if (k >= 63) begin
        lil = 1;
      end else begin
        lil = b.mag >> k;
        if ((b.mag & ((64'd1 << k) - 64'd1)) != 0) lil[0] = 1'b1;
      end
    end else begin
      big = a.mag << diff;
      lil = b.mag;
      base = b.ex;
    end
    if (a.neg == b.neg) begin
      mag = big + lil;
      neg = a.neg;
    end else if (big >= lil) begin
      mag = big - lil;
      neg = a.neg;
    end else begin
      mag = lil - big;
      neg = b.neg;
    end
    if (mag == 0) return 16'h0000;
    return pack_rne(neg, mag, base);
  endfunction

  function logic [15:0] add16(logic [15:0] x, logic [15:0] y);
    if (is_nan(x) || is_nan(y)) return cgss_pkg::HALF_QNAN;
    if (is_inf(x)) begin
      if (is_inf(y) && (x[15] != y[15])) return cgss_pkg::HALF_QNAN;
      return x;
    end
    if (is_inf(y)) return y;
    return sum_terms(split(x), split(y));
  endfunction

  function logic [15:0] mul16(logic [15:0] x, logic [15:0] y);
    half_term_t a, b;
    bit neg;
    neg = x[15] ^ y[15];
    if (is_nan(x) || is_nan(y)) return cgss_pkg::HALF_QNAN;
    if (is_inf(x) || is_inf(y)) begin
      if (x[14:0] == 15'd0 || y[14:0] == 15'd0) return cgss_pkg::HALF_QNAN;
      return {neg, 15'h7C00};
    end
    a = split(x);
    b = split(y);
    return pack_rne(neg, a.mag * b.mag, a.ex + b.ex);
  endfunction

  function logic [15:0] fma16(logic [15:0] x, logic [15:0] y, logic [15:0] z);
    half_term_t a, b, prod;
    bit pneg;
    pneg = x[15] ^ y[15];
    if (is_nan(x) || is_nan(y) || is_nan(z)) return cgss_pkg::HALF_QNAN;
    if (is_inf(x) || is_inf(y)) begin
      if (x[14:0] == 15'd0 || y[14:0] == 15'd0) return cgss_pkg::HALF_QNAN;
      if (is_inf(z) && z[15] != pneg) return cgss_pkg::HALF_QNAN;
      return {pneg, 15'h7C00};
    end
    if (is_inf(z)) return z;
    a = split(x);
    b = split(y);
    prod.neg = pneg;
    prod.mag = a.mag * b.mag;
    prod.ex = a.ex + b.ex;
    return sum_terms(prod, split(z));
  endfunction

  function void note_request(logic [15:0] sample, logic [15:0] mean, bit last, bit empty);
    logic [15:0] d, p, acc;
    if (empty) begin
      expected_sums.push_back(16'h0000);
      return;
    end
    d = add16(sample, mean ^ cgss_pkg::SIGN_BIT);
    p = mul16(d, scale);
    lanes[lane_pos] = fma16(p, d, lanes[lane_pos]);
    lane_pos = (lane_pos + 1) % cgss_pkg::ACC_COUNT_DEF;
    if (!last) return;
    acc = 16'h0000;
    foreach (lanes[i]) begin
      acc = add16(acc, lanes[i]);
      lanes[i] = 16'h0000;
    end
    lane_pos = 0;
    expected_sums.push_back(acc);
  endfunction

  function void check_sum(logic [15:0] got);
    logic [15:0] want;
    if (expected_sums.size() == 0) begin
      report("group_sum with nothing expected", got, 16'hxxxx);
      return;
    end
    want = expected_sums.pop_front();
    if (got !== want) report("group_sum", got, want);
  endfunction
endclass

module testbench;
  import cgss_pkg::*;

  localparam int IDLE_LIMIT = 6000;
  localparam int LONG_HOLD = 400;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [15:0] in_sample;
  logic [15:0] in_group_mean;
  logic        in_last_in_group;
  logic        in_empty_group;
  logic        out_valid;
  logic        out_stall;
  logic [15:0] out_group_sum;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  sumsq_scoreboard sb;
  int  idle_cycles;
  int  sent;
  bit  hold_long;     // asks the receiver for one long hold-off
  bit  steady_in;     // no gaps between requests while set
  bit  steady_out;    // no receiver stalls while set

  centered_group_square_sum_fp16 u_top (.*);

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // The watchdog only counts cycles in which neither channel moves a request,
  // so the long reduction walk and the long receiver hold stay well inside it.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout after %0d quiet cycles", idle_cycles);
        $display("FAIL centered_group_square_sum_fp16");
        $finish;
      end
    end
  end

  // Receiver: draws a stall length per result, sometimes a long hold, then
  // waits for a valid result. Sampling happens at the falling edge, where
  // every signal has settled since the last rising edge.
  initial begin
    int n;
    logic [15:0] got;
    @(posedge clk);
    forever begin
      n = steady_out ? 0 : $urandom_range(0, 7);
      if (hold_long) begin
        hold_long = 1'b0;
        n = LONG_HOLD;
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do begin
        @(negedge clk);
      end while (!out_valid);
      got = out_group_sum;
      @(posedge clk);
      sb.check_sum(got);
    end
  end

  // Sends one request. A gap lowers valid once; with no gap valid simply
  // stays high, so it is never lowered and raised in the same step.
  task automatic send_request(logic [15:0] sample, logic [15:0] mean, bit last, bit empty);
    int gap;
    gap = steady_in ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_sample <= sample;
    in_group_mean <= mean;
    in_last_in_group <= last;
    in_empty_group <= empty;
    do begin
      @(negedge clk);
    end while (in_stall);
    @(posedge clk);
    sb.note_request(sample, mean, last, empty);
    sent++;
  endtask

  // Waits until every predicted sum has come back, then lets the block drain.
  task automatic drain_block();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_sums.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Scale writes only happen with the block idle, so drain first.
  task automatic write_scale(logic [15:0] value);
    drain_block();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 3'd0;
    pwdata <= {16'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.scale = value;
  endtask

  // Mostly moderate fp16 values so the sums stay finite; one in eight is any
  // bit pattern, which brings in NaNs, infinities and subnormals.
  function automatic logic [15:0] pick_half();
    if ($urandom_range(0, 7) == 0) return 16'($urandom);
    return {1'($urandom), 5'($urandom_range(8, 20)), 10'($urandom)};
  endfunction

  task automatic send_group(int len);
    logic [15:0] mean;
    mean = pick_half();
    for (int i = 0; i < len; i++) begin
      send_request(pick_half(), ($urandom_range(0, 15) == 0) ? pick_half() : mean,
                   i == len - 1, 1'b0);
    end
  endtask

  initial begin
    int len;
    sb = new();
    sent = 0;
    idle_cycles = 0;
    hold_long = 1'b0;
    steady_in = 1'b0;
    steady_out = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_sample = 16'h0000;
    in_group_mean = 16'h0000;
    in_last_in_group = 1'b0;
    in_empty_group = 1'b0;
    out_stall = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = 3'd0;
    pwdata = 32'd0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part at the reset scale: plain groups, zero signs, overflow to
    // infinity, infinity minus infinity, NaN inputs, subnormals, and empty
    // groups with and without the group-end flag.
    send_request(16'h3C00, 16'h0000, 1'b1, 1'b0);
    send_request(16'h0000, 16'h8000, 1'b1, 1'b0);
    send_request(16'h8000, 16'h8000, 1'b1, 1'b0);
    send_request(16'h7BFF, 16'hFBFF, 1'b1, 1'b0);
    send_request(16'h7C00, 16'h7C00, 1'b1, 1'b0);
    send_request(16'hFFFF, 16'h0001, 1'b1, 1'b0);
    send_request(16'h0001, 16'h0000, 1'b0, 1'b0);
    send_request(16'h8001, 16'h0000, 1'b0, 1'b0);
    send_request(16'h03FF, 16'h8400, 1'b1, 1'b0);
    send_request(16'hFFFF, 16'hFFFF, 1'b1, 1'b1);
    send_request(16'h1234, 16'h4321, 1'b0, 1'b1);
    // An infinite lane meets a finite lane in the reduction and the sum stays infinite.
    send_request(16'h7C00, 16'h0000, 1'b0, 1'b0);
    send_request(16'h4000, 16'h3C00, 1'b1, 1'b0);
    send_request(16'h5A5A, 16'hA5A5, 1'b1, 1'b0);

    // Zero scale: infinity times zero is invalid.
    write_scale(16'h0000);
    send_request(16'h7C00, 16'h0000, 1'b1, 1'b0);
    send_request(16'h4500, 16'h3C00, 1'b1, 1'b0);
    // Negative infinite scale: both lanes end up as negative infinity, and so does the sum.
    write_scale(16'hFC00);
    send_request(16'h4000, 16'h3C00, 1'b0, 1'b0);
    send_request(16'hC000, 16'h3C00, 1'b1, 1'b0);
    write_scale(16'hFFFF);
    send_request(16'h3C00, 16'h3800, 1'b1, 1'b0);
    write_scale(16'h7BFF);
    send_request(16'h3C00, 16'h3800, 1'b1, 1'b0);

    // Random part: mostly whole groups of random length, now and then an
    // empty-group request, and once a group long enough to wrap the lanes.
    write_scale(16'h2C00);
    hold_long = 1'b1;
    steady_in = 1'b1;
    while (sent < 900) begin
      if (sent > 120 && sent < 200) steady_in = 1'b0;
      steady_out = (sent > 400 && sent < 480);
      if ($urandom_range(0, 11) == 0) begin
        send_request(16'($urandom), 16'($urandom), 1'($urandom), 1'b1);
      end else begin
        len = ($urandom_range(0, 19) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
        send_group(len);
      end
      if (sent >= 300 && sent < 320) begin
        send_group(cgss_pkg::ACC_COUNT_DEF + 30);
        write_scale(16'($urandom));
      end
      if (sent >= 650 && sent < 670) begin
        write_scale({1'b0, 5'($urandom_range(10, 16)), 10'($urandom)});
        send_group(3);
      end
    end

    drain_block();
    repeat (600) @(posedge clk);
    if (sb.errors == 0) begin
      $display("PASS centered_group_square_sum_fp16");
    end else begin
      $display("FAIL centered_group_square_sum_fp16");
    end
    $finish;
  end
endmodule
